@@ hdl/array_list_engine_macros.svh @@
// Assertion macros shared by the array list engine RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define ALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent
`define ALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ale_pkg.sv @@
// Shared codes for the array list engine: operation modes and result status.
// No dependencies.
package ale_pkg;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_SWAP   = 3'd2;
  localparam logic [2:0] MODE_SEARCH = 3'd3;
  localparam logic [2:0] MODE_MIN    = 3'd4;
  localparam logic [2:0] MODE_READ   = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

endpackage

@@ hdl/ale_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ale_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/array_list_engine.sv @@
// Array list engine top level: list store in one RAM plus length and operation sequencer.
// Depends on ale_pkg, ale_ram and array_list_engine_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request item: mode, value,
//   position and second_position. Output channel (out_valid_o / out_stall_i) carries
//   one result item per request: status, found_index, found_value, access_count and
//   current_length. An item moves when valid is high and stall is low.
//   One request is worked on at a time; the next one is taken as soon as the
//   sequencer is idle, even while the previous result still waits at the output.
//   Steps after accept:
//     append, insert at the end, failed or unknown request: none; read: capture the
//     read data; swap: read both entries, then write both; search: scan to a hit or
//     the end; minimum: scan the whole list; insert at p below the end: shift the
//     entries from p up one place, then place the value at p.
//   The scan and shift loops are set by the single read and write port of the RAM,
//   one entry per cycle; the next request can be taken, at the earliest, as the result turns valid.
//   Reset clears the length to zero and drops any pending result; store contents
//   stay undefined and are only read after being written.
//   While out_stall_i is high a finished result holds in the output register and
//   the sequencer waits with in_stall_o high until the register frees up.
`include "array_list_engine_macros.svh"

module array_list_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic [10:0]        position_i,
  input  logic [9:0]         second_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [9:0]         found_index_o,
  output logic signed [31:0] found_value_o,
  output logic [11:0]        access_count_o,
  output logic [10:0]        current_length_o
);

  localparam int LenW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = LenW + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FINISH   = 4'd1;
  localparam logic [3:0] S_INS      = 4'd2;
  localparam logic [3:0] S_INS_TAIL = 4'd3;
  localparam logic [3:0] S_INS_PUT  = 4'd4;
  localparam logic [3:0] S_SW_RD2   = 4'd5;
  localparam logic [3:0] S_SW_WR1   = 4'd6;
  localparam logic [3:0] S_SW_WR2   = 4'd7;
  localparam logic [3:0] S_SRCH     = 4'd8;
  localparam logic [3:0] S_MIN      = 4'd9;
  localparam logic [3:0] S_READ     = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  ptr_q, ptr_d;
  logic [LenW-1:0]  cmp_q, cmp_d;
  logic [LenW-1:0]  pend_addr_q, pend_addr_d;
  logic             pend_q, pend_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [AddrW-1:0] pos2_q, pos2_d;
  logic [31:0]      val_q, val_d;
  logic [31:0]      tmp_q, tmp_d;
  logic [2:0]       st_q, st_d;
  logic [AddrW-1:0] fidx_q, fidx_d;
  logic [31:0]      fval_q, fval_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       status_q;
  logic [9:0]       found_index_q;
  logic [31:0]      found_value_q;
  logic [11:0]      access_count_q;
  logic [10:0]      current_length_q;

  logic             we;
  logic [AddrW-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [31:0]      rd_data;

  logic             in_accept;
  logic             out_free;
  logic             list_full;
  logic             list_empty;
  logic [31:0]      len32;
  logic [31:0]      fidx32;
  logic [31:0]      cnt32;
  logic [LenW-1:0]  last_idx;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign list_full  = (len_q == LenW'(CAPACITY));
  assign list_empty = (len_q == '0);
  assign last_idx   = len_q - 1'b1;
  assign len32      = 32'(len_q);
  assign fidx32     = 32'(fidx_q);
  assign cnt32      = 32'(cnt_q);

  // List store
  ale_ram #(
    .Width (32),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequence operations over the store
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    cmp_d       = cmp_q;
    pend_addr_d = pend_addr_q;
    pend_d      = pend_q;
    pos_d       = pos_q;
    pos2_d      = pos2_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    st_d        = st_q;
    fidx_d      = fidx_q;
    fval_d      = fval_q;
    cnt_d       = cnt_q;
    we          = 1'b0;
    wr_addr     = AddrW'(pos_q);
    wr_data     = val_q;
    rd_en       = 1'b0;
    rd_addr     = AddrW'(ptr_q);

    case (state_q)
      S_IDLE: begin
        // Start a request: check bounds and issue the first access
        rd_addr = ((mode_i == ale_pkg::MODE_SWAP) || (mode_i == ale_pkg::MODE_READ)) ?
                  AddrW'(position_i) : '0;
        if (in_accept) begin
          rd_en  = 1'b1;
          st_d   = ale_pkg::ST_OK;
          fidx_d = '0;
          fval_d = '0;
          cnt_d  = '0;
          val_d  = value_i;
          pos_d  = LenW'(position_i);
          pos2_d = AddrW'(second_position_i);
          state_d = S_FINISH;
          case (mode_i)
            ale_pkg::MODE_APPEND: begin
              if (list_full) begin
                st_d = ale_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = AddrW'(len_q);
                wr_data = value_i;
                len_d   = len_q + 1'b1;
              end
            end
            ale_pkg::MODE_INSERT: begin
              if (32'(position_i) > len32) begin
                st_d = ale_pkg::ST_BADPOS;
              end else if (list_full) begin
                st_d = ale_pkg::ST_FULL;
              end else if (32'(position_i) == len32) begin
                we      = 1'b1;
                wr_addr = AddrW'(len_q);
                wr_data = value_i;
                len_d   = len_q + 1'b1;
              end else begin
                ptr_d   = last_idx;
                pend_d  = 1'b0;
                state_d = S_INS;
              end
            end
            ale_pkg::MODE_SWAP: begin
              if (list_empty) begin
                st_d = ale_pkg::ST_EMPTY;
              end else if ((32'(position_i) >= len32) ||
                           (32'(second_position_i) >= len32)) begin
                st_d = ale_pkg::ST_BADPOS;
              end else begin
                state_d = S_SW_RD2;
              end
            end
            ale_pkg::MODE_SEARCH: begin
              if (list_empty) begin
                st_d = ale_pkg::ST_EMPTY;
              end else begin
                ptr_d   = LenW'(1);
                cmp_d   = '0;
                state_d = S_SRCH;
              end
            end
            ale_pkg::MODE_MIN: begin
              if (list_empty) begin
                st_d = ale_pkg::ST_EMPTY;
              end else begin
                ptr_d   = LenW'(1);
                cmp_d   = '0;
                state_d = S_MIN;
              end
            end
            ale_pkg::MODE_READ: begin
              if (list_empty) begin
                st_d = ale_pkg::ST_EMPTY;
              end else if (32'(position_i) >= len32) begin
                st_d = ale_pkg::ST_BADPOS;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              st_d = ale_pkg::ST_OK;
            end
          endcase
        end
      end

      S_INS: begin
        // Shift entries up: read one entry while writing the one read last cycle
        rd_en       = 1'b1;
        rd_addr     = AddrW'(ptr_q);
        we          = pend_q;
        wr_addr     = AddrW'(pend_addr_q + 1'b1);
        wr_data     = rd_data;
        pend_d      = 1'b1;
        pend_addr_d = ptr_q;
        if (ptr_q == pos_q) begin
          state_d = S_INS_TAIL;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end

      S_INS_TAIL: begin
        // Write the last shifted entry
        we      = 1'b1;
        wr_addr = AddrW'(pend_addr_q + 1'b1);
        wr_data = rd_data;
        state_d = S_INS_PUT;
      end

      S_INS_PUT: begin
        // Place the new value and grow the list
        we      = 1'b1;
        wr_addr = AddrW'(pos_q);
        wr_data = val_q;
        len_d   = len_q + 1'b1;
        state_d = S_FINISH;
      end

      S_SW_RD2: begin
        // Hold the first entry, fetch the second
        rd_en   = 1'b1;
        rd_addr = pos2_q;
        tmp_d   = rd_data;
        state_d = S_SW_WR1;
      end

      S_SW_WR1: begin
        we      = 1'b1;
        wr_addr = AddrW'(pos_q);
        wr_data = rd_data;
        state_d = S_SW_WR2;
      end

      S_SW_WR2: begin
        we      = 1'b1;
        wr_addr = pos2_q;
        wr_data = tmp_q;
        state_d = S_FINISH;
      end

      S_SRCH: begin
        // Compare the entry that arrived, prefetch the next one
        if (ptr_q < len_q) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end
        cmp_d = cmp_q + 1'b1;
        if (rd_data == val_q) begin
          st_d    = ale_pkg::ST_OK;
          fidx_d  = AddrW'(cmp_q);
          cnt_d   = CntW'(cmp_q) + 1'b1;
          state_d = S_FINISH;
        end else if (cmp_q == last_idx) begin
          st_d    = ale_pkg::ST_NOTFOUND;
          cnt_d   = CntW'(len_q);
          state_d = S_FINISH;
        end
      end

      S_MIN: begin
        // Track the running minimum; a new minimum costs one more access
        if (ptr_q < len_q) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end
        cmp_d = cmp_q + 1'b1;
        if (cmp_q == '0) begin
          fval_d = rd_data;
          fidx_d = '0;
          cnt_d  = CntW'(1);
        end else if ($signed(rd_data) < $signed(fval_q)) begin
          fval_d = rd_data;
          fidx_d = AddrW'(cmp_q);
          cnt_d  = cnt_q + CntW'(2);
        end else begin
          cnt_d  = cnt_q + 1'b1;
        end
        if (cmp_q == last_idx) begin
          state_d = S_FINISH;
        end
      end

      S_READ: begin
        fval_d  = rd_data;
        state_d = S_FINISH;
      end

      S_FINISH: begin
        // Wait for the output register, then go idle
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_FINISH) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    cmp_q       <= cmp_d;
    pend_addr_q <= pend_addr_d;
    pos_q       <= pos_d;
    pos2_q      <= pos2_d;
    val_q       <= val_d;
    tmp_q       <= tmp_d;
    st_q        <= st_d;
    fidx_q      <= fidx_d;
    fval_q      <= fval_d;
    cnt_q       <= cnt_d;
  end

  // Load the result item
  always_ff @(posedge clk_i) begin
    if ((state_q == S_FINISH) && out_free) begin
      status_q         <= st_q;
      found_index_q    <= fidx32[9:0];
      found_value_q    <= fval_q;
      access_count_q   <= cnt32[11:0];
      current_length_q <= len32[10:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_index_o    = found_index_q;
  assign found_value_o    = found_value_q;
  assign access_count_o   = access_count_q;
  assign current_length_o = current_length_q;

  // Assertions
  `ALE_ASSERT_NOW(a_len_cap, 1'b1, len32 <= 32'(CAPACITY), "list length above capacity")
  `ALE_ASSERT_NEXT(a_busy_after_accept, in_accept, state_q != S_IDLE, "idle after accept")
  `ALE_ASSERT_NOW(a_result_from_finish, $rose(out_valid_q), $past(state_q) == S_FINISH,
                  "result without finish")
  `ALE_ASSERT_NOW(a_len_step, len_q != $past(len_q), len_q == $past(len_q) + 1'b1,
                  "length changed by other than one")
  `ALE_ASSERT_NOW(a_scan_no_write, (state_q == S_SRCH) || (state_q == S_MIN), !we,
                  "store written during scan")

endmodule

@@ tb/tb_array_list_engine.sv @@
// Self-checking testbench for array_list_engine: random and directed list requests,
// checked against a behavioral list model kept in the bench. Depends on ale_pkg and array_list_engine.
`timescale 1ns / 1ps

module tb_array_list_engine;

  localparam int          LIST_CAP    = 1024;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] val;
    logic [10:0] pos;
    logic [9:0]  pos2;
    bit          drain;
  } list_request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  index;
    logic [31:0] value;
    logic [11:0] count;
    logic [10:0] length;
  } list_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         mode_i = '0;
  logic signed [31:0] value_i = '0;
  logic [10:0]        position_i = '0;
  logic [9:0]         second_position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [9:0]         found_index_o;
  logic signed [31:0] found_value_o;
  logic [11:0]        access_count_o;
  logic [10:0]        current_length_o;

  list_request_t      request_queue[$];
  list_result_t       pending_results[$];
  logic signed [31:0] shadow_list[LIST_CAP];
  int                 shadow_len = 0;
  int                 plan_len = 0;
  logic [31:0]        plan_values[$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  logic               in_taken = 1'b0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;

  array_list_engine #(.CAPACITY(LIST_CAP)) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .value_i           (value_i),
    .position_i        (position_i),
    .second_position_i (second_position_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .found_index_o     (found_index_o),
    .found_value_o     (found_value_o),
    .access_count_o    (access_count_o),
    .current_length_o  (current_length_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one request to the shadow list and return the result it must produce
  function automatic list_result_t apply_request(logic [2:0] op, logic signed [31:0] val,
                                                 logic [10:0] pos, logic [9:0] pos2);
    list_result_t       res;
    logic signed [31:0] best;
    logic signed [31:0] held;
    int                 k;
    res = '0;
    res.status = ale_pkg::ST_OK;
    case (op)
      ale_pkg::MODE_APPEND: begin
        if (shadow_len >= LIST_CAP) begin
          res.status = ale_pkg::ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      ale_pkg::MODE_INSERT: begin
        if (pos > shadow_len) begin
          res.status = ale_pkg::ST_BADPOS;
        end else if (shadow_len >= LIST_CAP) begin
          res.status = ale_pkg::ST_FULL;
        end else begin
          for (k = shadow_len; k > pos; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      ale_pkg::MODE_SWAP: begin
        if (shadow_len == 0) begin
          res.status = ale_pkg::ST_EMPTY;
        end else if (pos >= shadow_len || pos2 >= shadow_len) begin
          res.status = ale_pkg::ST_BADPOS;
        end else begin
          held = shadow_list[pos];
          shadow_list[pos] = shadow_list[pos2];
          shadow_list[pos2] = held;
        end
      end
      ale_pkg::MODE_SEARCH: begin
        if (shadow_len == 0) begin
          res.status = ale_pkg::ST_EMPTY;
        end else begin
          // a miss keeps the count of entries read
          res.status = ale_pkg::ST_NOTFOUND;
          for (k = 0; k < shadow_len; k++) begin
            res.count = res.count + 12'd1;
            if (shadow_list[k] == val) begin
              res.status = ale_pkg::ST_OK;
              res.index = 10'(k);
              break;
            end
          end
        end
      end
      ale_pkg::MODE_MIN: begin
        if (shadow_len == 0) begin
          res.status = ale_pkg::ST_EMPTY;
        end else begin
          // one access per entry read, one more per new minimum
          best = shadow_list[0];
          res.count = 12'd1;
          for (k = 1; k < shadow_len; k++) begin
            res.count = res.count + 12'd1;
            if (shadow_list[k] < best) begin
              best = shadow_list[k];
              res.index = 10'(k);
              res.count = res.count + 12'd1;
            end
          end
          res.value = best;
        end
      end
      ale_pkg::MODE_READ: begin
        if (shadow_len == 0) res.status = ale_pkg::ST_EMPTY;
        else if (pos >= shadow_len) res.status = ale_pkg::ST_BADPOS;
        else res.value = shadow_list[pos];
      end
      default: ;
    endcase
    res.length = 11'(shadow_len);
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return 32'($urandom_range(0, 15) - 8);
      default: return $urandom();
    endcase
  endfunction

  // Queue one request and track the list length it leaves behind
  task automatic add_request(logic [2:0] op, logic [31:0] val, logic [10:0] pos,
                             logic [9:0] pos2, bit drain);
    list_request_t req;
    req.op = op;
    req.val = val;
    req.pos = pos;
    req.pos2 = pos2;
    req.drain = drain;
    request_queue.push_back(req);
    if (plan_len < LIST_CAP &&
        (op == ale_pkg::MODE_APPEND || (op == ale_pkg::MODE_INSERT && pos <= plan_len))) begin
      plan_len++;
      plan_values.push_back(val);
    end
  endtask

  // Mostly well-formed requests against the current length, some out of range
  task automatic add_random_request(bit drain);
    int          pick;
    logic [31:0] val;
    logic [10:0] pos;
    logic [9:0]  pos2;
    pick = $urandom_range(0, 99);
    val = rand_word();
    pos = 11'($urandom_range(0, 2047));
    pos2 = 10'($urandom_range(0, 1023));
    if (pick < 20) begin
      add_request(ale_pkg::MODE_APPEND, val, pos, pos2, drain);
    end else if (pick < 38) begin
      if ($urandom_range(0, 6) != 0) pos = 11'($urandom_range(0, plan_len));
      add_request(ale_pkg::MODE_INSERT, val, pos, pos2, drain);
    end else if (pick < 52) begin
      if (plan_len > 0 && $urandom_range(0, 6) != 0) begin
        pos = 11'($urandom_range(0, plan_len - 1));
        pos2 = 10'($urandom_range(0, plan_len - 1));
      end
      add_request(ale_pkg::MODE_SWAP, val, pos, pos2, drain);
    end else if (pick < 68) begin
      if (plan_values.size() > 0 && $urandom_range(0, 4) < 3)
        val = plan_values[$urandom_range(0, plan_values.size() - 1)];
      add_request(ale_pkg::MODE_SEARCH, val, pos, pos2, drain);
    end else if (pick < 78) begin
      add_request(ale_pkg::MODE_MIN, val, pos, pos2, drain);
    end else if (pick < 95) begin
      if (plan_len > 0 && $urandom_range(0, 6) != 0) pos = 11'($urandom_range(0, plan_len - 1));
      add_request(ale_pkg::MODE_READ, val, pos, pos2, drain);
    end else begin
      add_request($urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7, val, pos, pos2, drain);
    end
  endtask

  task automatic check_field(string what, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Build the stimulus, release reset, then wait for the list engine to drain
  initial begin
    int k;
    // empty list: every scan and access fails
    add_request(ale_pkg::MODE_SEARCH, 32'd5, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_MIN, 32'd0, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_READ, 32'd0, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_SWAP, 32'd0, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_INSERT, 32'd9, 11'd1, 10'd0, 1'b0);
    add_request(MODE_SPARE6, 32'hffff_ffff, 11'h7ff, 10'h3ff, 1'b0);
    // load with extremes, inserting at front, end and middle
    add_request(ale_pkg::MODE_INSERT, 32'h7fff_ffff, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_APPEND, 32'h8000_0000, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_APPEND, 32'd0, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_APPEND, 32'hffff_ffff, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_INSERT, 32'd1, 11'd4, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_INSERT, 32'hffff_ffff, 11'd2, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_INSERT, 32'd3, 11'h7ff, 10'd0, 1'b0);
    // swaps in and out of range on either position
    add_request(ale_pkg::MODE_SWAP, 32'd0, 11'd0, 10'd5, 1'b0);
    add_request(ale_pkg::MODE_SWAP, 32'd0, 11'd1, 10'h3ff, 1'b0);
    add_request(ale_pkg::MODE_SWAP, 32'd0, 11'd6, 10'd0, 1'b0);
    // duplicate hit, miss, minimum and reads
    add_request(ale_pkg::MODE_SEARCH, 32'hffff_ffff, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_SEARCH, 32'd12345, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_MIN, 32'd0, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_READ, 32'd0, 11'd5, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_READ, 32'd0, 11'd6, 10'd0, 1'b0);
    add_request(MODE_SPARE7, 32'd0, 11'd0, 10'd0, 1'b0);
    add_request(ale_pkg::MODE_SEARCH, 32'h8000_0000, 11'd0, 10'd0, 1'b0);
    // random traffic on a growing list
    for (k = 0; k < 500; k++) add_random_request(1'b0);
    // hold the sender until every result so far has come back
    add_request(ale_pkg::MODE_MIN, 32'd0, 11'd0, 10'd0, 1'b1);
    add_request(ale_pkg::MODE_SEARCH, 32'd12345, 11'd0, 10'd0, 1'b0);
    for (k = 0; k < 50; k++) add_random_request(1'b0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() > 0 || in_valid_i) @(posedge clk_i);
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (LIST_CAP + 8) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Request driver: bursts with random gaps, hold each item until taken
  always @(negedge clk_i) begin
    list_request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the stalled item
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (request_queue.size() > 0 &&
                 !(request_queue[0].drain && pending_results.size() > 0)) begin
      req = request_queue.pop_front();
      mode_i <= req.op;
      value_i <= req.val;
      position_i <= req.pos;
      second_position_i <= req.pos2;
      in_valid_i <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result stall pattern: quiet stretches, solid stalls and choppy runs
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall_i <= 1'b0;
          stall_left <= $urandom_range(16, 48);
        end
        1: begin
          out_stall_i <= 1'b1;
          stall_left <= $urandom_range(0, 5);
        end
        default: begin
          out_stall_i <= 1'($urandom_range(0, 1));
          stall_left <= $urandom_range(0, 2);
        end
      endcase
    end
  end

  // Predict on each accepted request, then check each accepted result
  always @(posedge clk_i) begin
    list_result_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("== FAIL ==");
        $finish;
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(apply_request(mode_i, value_i, position_i, second_position_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual status %0d length %0d",
                   $time, status_o, current_length_o);
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, status_o);
          check_field("found_index", want.index, found_index_o);
          check_field("found_value", $signed(want.value), found_value_o);
          check_field("access_count", want.count, access_count_o);
          check_field("current_length", want.length, current_length_o);
        end
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ale_pkg.sv
hdl/ale_ram.sv
hdl/array_list_engine.sv
tb/tb_array_list_engine.sv
